/* rtl/sis_pkg.sv */
package sis_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int OP_W             = 2;
    localparam int VALUE_W          = 64;
    localparam int STATUS_W         = 2;
    localparam int WCLASS_W         = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_GET    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_FULL    = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef enum logic [WCLASS_W-1:0] {
        WC_16 = 2'd0,
        WC_32 = 2'd1,
        WC_64 = 2'd2
    } wclass_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_CMP,
        FSM_APPLY
    } fsm_t;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
    } cell_ctrl_t;

endpackage

/* rtl/sorted_integer_set.sv */
// Sorted set of distinct signed 64-bit integers, kept in a row of compare cells.
// Input channel (s_): one word per request: operation, value, position.
//   Operations: add, remove, find, get by sorted position.
// Result channel (m_): one word per request: status, read value, entry count
//   after the request, and the element width class (16, 32 or 64 bits), which
//   only widens as wider values are added.
// Each request passes through a compare state, in which every cell compares its
//   entry with the value, then an apply state, in which the cells at and above
//   the value's place shift at once for an add or remove and the result is registered.
// Only one request is in flight; s_tready is high while the block is idle and
//   in the cycle a result is registered, so the next request overlaps it.
// When the receiver stalls, the result holds in the output register. A next request
//   may be taken; it waits in apply, cells held, s_tready low, until the result is taken.
// Reset (aresetn low, synchronous) empties the set, sets the width class to
//   16 bits and drops any pending result. Entry storage is not cleared; only
//   positions below the count are ever read.
module sorted_integer_set #(
    parameter int CAPACITY = sis_pkg::DEFAULT_CAPACITY,
    parameter int POS_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int S_W      = ((sis_pkg::OP_W + sis_pkg::VALUE_W + POS_W + 7) / 8) * 8,
    parameter int M_W      = ((sis_pkg::STATUS_W + sis_pkg::VALUE_W + CNT_W
                               + sis_pkg::WCLASS_W + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [S_W-1:0] s_tdata,  // operation, value, position, zero pad
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [M_W-1:0] m_tdata   // status, read_value, entry_count, width_class, zero pad
);
    import sis_pkg::*;

    localparam int POS_LO = OP_W + VALUE_W;
    localparam int CNT_LO = STATUS_W + VALUE_W;
    localparam int WC_LO  = CNT_LO + CNT_W;
    localparam int M_PAD  = M_W - WC_LO - WCLASS_W;

    fsm_t               state_reg, state_next;
    op_t                op_reg;
    logic signed [63:0] value_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    wclass_t            wc_reg, wc_next;
    logic               m_valid_reg, m_valid_next;
    status_t            status_reg, status_next;
    logic [63:0]        rd_reg, rd_next;

    cell_ctrl_t  ctrl;
    logic [63:0] entries [CAPACITY];
    logic        found;
    logic        accept;
    logic        commit;
    logic        full;
    logic        fits16;
    logic        fits32;
    wclass_t     v_class;

    sis_chain #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_chain (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .value   (value_reg),
        .count   (count_reg),
        .entries (entries),
        .found   (found)
    );

    assign full   = count_reg == CNT_W'(CAPACITY);
    assign fits16 = (&value_reg[63:15]) || !(|value_reg[63:15]);
    assign fits32 = (&value_reg[63:31]) || !(|value_reg[63:31]);
    assign v_class = fits16 ? WC_16 : (fits32 ? WC_32 : WC_64);

    assign commit   = (state_reg == FSM_APPLY) && (!m_valid_reg || m_tready);
    assign s_tready = (state_reg == FSM_IDLE) || commit;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        wc_next      = wc_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        rd_next      = rd_reg;
        ctrl         = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    state_next = FSM_CMP;
                end
            end
            FSM_CMP: begin
                ctrl.cmp   = 1'b1;
                state_next = FSM_APPLY;
            end
            FSM_APPLY: begin
                if (commit) begin
                    m_valid_next = 1'b1;
                    status_next  = ST_DONE;
                    rd_next      = '0;
                    case (op_reg)
                        OP_ADD: begin
                            if (found) begin
                                status_next = ST_ABSENT;
                            end else if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                ctrl.ins   = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (v_class > wc_reg) begin
                                    wc_next = v_class;
                                end
                            end
                        end
                        OP_REMOVE: begin
                            if (found) begin
                                ctrl.rem   = 1'b1;
                                count_next = count_reg - 1'b1;
                            end else begin
                                status_next = ST_ABSENT;
                            end
                        end
                        OP_FIND: begin
                            if (!found) begin
                                status_next = ST_ABSENT;
                            end
                        end
                        OP_GET: begin
                            if (CNT_W'(pos_reg) < count_reg) begin
                                rd_next = entries[pos_reg];
                            end else begin
                                status_next = ST_RANGE;
                            end
                        end
                        default: begin
                            status_next = ST_DONE;
                        end
                    endcase
                    state_next = accept ? FSM_CMP : FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            wc_reg      <= WC_16;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wc_reg      <= wc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        rd_reg     <= rd_next;
        if (accept) begin
            op_reg    <= op_t'(s_tdata[OP_W-1:0]);
            value_reg <= s_tdata[POS_LO-1:OP_W];
            pos_reg   <= s_tdata[POS_LO +: POS_W];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD{1'b0}}, wc_reg, count_reg, rd_reg, status_reg};

endmodule

/* rtl/sis_cell.sv */
module sis_cell (
    input  logic                       aclk,
    input  sis_pkg::cell_ctrl_t        ctrl,
    input  logic signed [63:0]         value,
    input  logic                       occupied,
    input  logic                       left_lt,
    input  logic        [63:0]         left_entry,
    input  logic        [63:0]         right_entry,
    output logic        [63:0]         entry,
    output logic                       lt,
    output logic                       eq
);
    import sis_pkg::*;

    logic [63:0] entry_reg;
    logic [63:0] entry_next;
    logic        lt_reg;
    logic        eq_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins && !lt_reg) begin
            entry_next = left_lt ? value : left_entry;
        end else if (ctrl.rem && !lt_reg) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (ctrl.cmp) begin
            lt_reg <= occupied && ($signed(entry_reg) < value);
            eq_reg <= occupied && (entry_reg == value);
        end
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

/* rtl/sis_chain.sv */
module sis_chain #(
    parameter int CAPACITY = sis_pkg::DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                       aclk,
    input  sis_pkg::cell_ctrl_t        ctrl,
    input  logic signed [63:0]         value,
    input  logic        [CNT_W-1:0]    count,
    output logic        [63:0]         entries [CAPACITY],
    output logic                       found
);
    import sis_pkg::*;

    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] eq_vec;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic        occupied;
        logic        left_lt;
        logic [63:0] left_entry;
        logic [63:0] right_entry;

        assign occupied = CNT_W'(i) < count;

        if (i == 0) begin : g_first
            assign left_lt    = 1'b1;
            assign left_entry = value;
        end else begin : g_mid
            assign left_lt    = lt_vec[i-1];
            assign left_entry = entries[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_entry = entries[i];
        end else begin : g_inner
            assign right_entry = entries[i+1];
        end

        sis_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .value       (value),
            .occupied    (occupied),
            .left_lt     (left_lt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .lt          (lt_vec[i]),
            .eq          (eq_vec[i])
        );
    end

    assign found = |eq_vec;

endmodule
